// ===== rtl/stbs_pkg.sv =====
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int KEY_W = 32;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;   // start a search: latch key, set bounds
    logic wr;     // store a table word
    logic probe;  // read the midpoint entry
    logic step;   // compare; move a bound, or record a hit
    logic post;   // load the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic more;   // low has not passed high
    logic eq;     // probed entry equals the key
  } status_t;

endpackage

// ===== rtl/stbs_ctrl.sv =====
`timescale 1ns / 1ps

module stbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             operation,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  stbs_pkg::status_t status,
  output stbs_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PROBE = 4'b0010,
    S_CMP   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (operation == stbs_pkg::OP_SEARCH) begin
            cmd.load   = 1'b1;
            state_next = S_PROBE;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_PROBE: begin
        if (status.more) begin
          cmd.probe  = 1'b1;
          state_next = S_CMP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CMP: begin
        cmd.step   = 1'b1;
        state_next = status.eq ? S_DONE : S_PROBE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.post) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // result never overwrites a word still waiting
  a_post_free: assert property (@(posedge clk) disable iff (rst)
    cmd.post |-> slot_free)
    else $error("result posted over a pending word");

  // a search always starts with a bound check
  a_load_probe: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_PROBE)
    else $error("search did not enter probe");

  // each compare follows a memory read
  a_cmp_after_probe: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(cmd.probe))
    else $error("compare without a read");

endmodule

// ===== rtl/stbs_dp.sv =====
`timescale 1ns / 1ps

module stbs_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [stbs_pkg::CNT_W-1:0]    cfg_data,
  input  logic [stbs_pkg::IDX_W-1:0]    entry_index,
  input  logic signed [stbs_pkg::KEY_W-1:0] key,
  input  stbs_pkg::cmd_t                cmd,
  output stbs_pkg::status_t             status,
  output logic                          found,
  output logic [stbs_pkg::IDX_W-1:0]    match_index
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [stbs_pkg::KEY_W-1:0] mem [TABLE_DEPTH];

  logic [stbs_pkg::CNT_W-1:0]        entry_count;
  logic signed [stbs_pkg::KEY_W-1:0] key_q;
  logic signed [stbs_pkg::KEY_W-1:0] rdata;
  logic [CW-1:0]                     lo, hi_ex;   // hi_ex = high + 1
  logic [AW-1:0]                     mid_q;
  logic                              hit;

  logic [31:0]   idx32, cnt32, mid32;
  logic [CW-1:0] n_sat, span, mid_w;
  logic          wr_ok;

  assign idx32 = 32'(entry_index);
  assign cnt32 = 32'(entry_count);
  assign wr_ok = idx32 < 32'(TABLE_DEPTH);
  assign n_sat = (cnt32 > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(entry_count);

  // mid = low + (high - low) / 2, with high = hi_ex - 1
  assign span  = hi_ex - lo - CW'(1);
  assign mid_w = lo + (span >> 1);
  assign mid32 = 32'(mid_q);

  assign status.more = lo < hi_ex;
  assign status.eq   = (rdata == key_q);

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) begin
      mem[idx32[AW-1:0]] <= key;
    end
    if (cmd.probe) begin
      rdata <= mem[mid_w[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      lo          <= '0;
      hi_ex       <= '0;
      hit         <= 1'b0;
    end else begin
      if (cfg_write) begin
        entry_count <= cfg_data;
      end
      if (cmd.load) begin
        lo    <= '0;
        hi_ex <= n_sat;
        hit   <= 1'b0;
      end else if (cmd.step) begin
        if (status.eq) begin
          hit <= 1'b1;
        end else if (rdata < key_q) begin
          lo <= CW'(mid_q) + CW'(1);
        end else begin
          hi_ex <= CW'(mid_q);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q <= key;
    end
    if (cmd.probe) begin
      mid_q <= mid_w[AW-1:0];
    end
    if (cmd.post) begin
      found       <= hit;
      match_index <= hit ? mid32[stbs_pkg::IDX_W-1:0] : '0;
    end
  end

  // bounds stay ordered once a search has set them
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    lo <= hi_ex)
    else $error("low bound passed exclusive high");

  // a hit ends the search: no further moves of the bounds
  a_hit_freeze: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.eq) |=> ($stable(lo) && $stable(hi_ex)))
    else $error("bounds moved on a hit");

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
`timescale 1ns / 1ps

// Binary search over a table of signed 32-bit keys held in on-chip RAM.
// Config: cfg_write/cfg_data load entry_count (entries searched), change it
//   only while the block is idle; values above TABLE_DEPTH act as TABLE_DEPTH.
// Input channel (in_valid/in_ready): one word per item. operation = write
//   stores key at entry_index (ignored if beyond the table), one per cycle
//   while no search is in flight, no result word. operation = search looks
//   key up in entries 0..entry_count-1 and yields one result word.
// Output channel (out_valid/out_ready): found and match_index (0 on a miss).
// Sequence: each probe is one synchronous RAM read (PROBE), then one
//   compare/bound update (CMP); a miss ends with one more bound check in
//   PROBE. A search does k <= ceil(log2(n+1)) probes for n entries.
//   in_ready is back in the same cycle that out_valid rises; one search is
//   in flight at a time.
// Stall: the result sits in an output register; while it waits, the block
//   still accepts the next word. A finished search waits in its last state
//   until that register is free.
// Reset: clears entry_count, the controller and out_valid; table contents
//   are undefined until written.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [stbs_pkg::CNT_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              operation,
  input  logic [stbs_pkg::IDX_W-1:0]        entry_index,
  input  logic signed [stbs_pkg::KEY_W-1:0] key,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic [stbs_pkg::IDX_W-1:0]        match_index
);

  stbs_pkg::cmd_t    cmd;
  stbs_pkg::status_t status;

  // sequencer: accept, probe/compare loop, result handoff
  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // table RAM, bounds, midpoint and output register
  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .entry_index (entry_index),
    .key         (key),
    .cmd         (cmd),
    .status      (status),
    .found       (found),
    .match_index (match_index)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Testbench for sorted_table_binary_search.
// Write words and search words go in over the valid/ready input channel. A
// shadow copy of the key table and of entry_count follows every accepted word.
// Each search's answer, from the shadow copy or its directed row, is queued.
// Result words are popped in order and checked field by field.
// Both channels idle and stall at random. Some phases run with no idling.
module testbench;

  localparam int DEPTH        = 1024;
  localparam int SETTLE       = 40;    // longer than the worst search latency
  localparam int PHASE_WORDS  = 60;
  localparam int PHASES       = 10;

  typedef struct packed {
    logic                       found;
    logic [stbs_pkg::IDX_W-1:0] match_index;
  } answer_t;

  // directed stimulus: either a count write or one input word
  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct packed {
    row_kind_e                         kind;
    logic                              op;
    logic [stbs_pkg::IDX_W-1:0]        idx;
    logic signed [stbs_pkg::KEY_W-1:0] key;
    logic [stbs_pkg::CNT_W-1:0]        cnt;
    logic                              typed;     // expected answer given in the row
    logic                              found;
    logic [stbs_pkg::IDX_W-1:0]        match;
  } dir_row_t;

  localparam logic signed [stbs_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [stbs_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  logic                              clk;
  logic                              rst;
  logic                              cfg_write;
  logic [stbs_pkg::CNT_W-1:0]        cfg_data;
  logic                              in_valid;
  logic                              in_ready;
  logic                              operation;
  logic [stbs_pkg::IDX_W-1:0]        entry_index;
  logic signed [stbs_pkg::KEY_W-1:0] key;
  logic                              out_valid;
  logic                              out_ready;
  logic                              found;
  logic [stbs_pkg::IDX_W-1:0]        match_index;

  // shadow state of the block
  logic signed [stbs_pkg::KEY_W-1:0] shadow_keys [DEPTH];
  bit                                shadow_written [DEPTH];
  logic [stbs_pkg::CNT_W-1:0]        shadow_count;

  answer_t                 pending_answers [$];
  answer_t                 head_answer;
  int                      mismatches = 0;
  bit                      calm;     // no idling on either side

  // key layout of the current random phase: base + i*step (mostly ascending)
  logic [stbs_pkg::KEY_W-1:0] layout_base;
  logic [stbs_pkg::KEY_W-1:0] layout_step;

  dir_row_t                dir_rows [24];

  sorted_table_binary_search u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .entry_index (entry_index),
    .key         (key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .match_index (match_index)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Binary search over the shadow table. hole is the first probed entry that
  // was never written (-1 if none); the search stops there, since such a
  // search must not be sent.
  function automatic void look_up(input logic signed [stbs_pkg::KEY_W-1:0] want,
                                  output logic hit,
                                  output logic [stbs_pkg::IDX_W-1:0] at,
                                  output int hole);
    int lo;
    int hi;
    int mid;
    lo   = 0;
    hi   = ((shadow_count > DEPTH) ? DEPTH : int'(shadow_count)) - 1;
    hit  = 1'b0;
    at   = '0;
    hole = -1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (!shadow_written[mid]) begin
        hole = mid;
        return;
      end
      if (shadow_keys[mid] == want) begin
        hit = 1'b1;
        at  = stbs_pkg::IDX_W'(mid);
        return;
      end else if (shadow_keys[mid] < want) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
  endfunction

  function automatic logic signed [stbs_pkg::KEY_W-1:0] layout_key(int i);
    return layout_base + stbs_pkg::KEY_W'(i) * layout_step;
  endfunction

  // Present one word, hold it until accepted, then update the shadow state.
  // Valid is only lowered when a gap is drawn, so it never drops and rises
  // in the same step.
  task automatic send_word(input logic op, input logic [stbs_pkg::IDX_W-1:0] idx,
                           input logic signed [stbs_pkg::KEY_W-1:0] k,
                           input logic typed, input logic exp_found,
                           input logic [stbs_pkg::IDX_W-1:0] exp_index);
    int                         gap;
    logic                       hit;
    logic [stbs_pkg::IDX_W-1:0] at;
    int                         hole;
    gap = calm ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    entry_index <= idx;
    key         <= k;
    do @(posedge clk); while (!in_ready);
    if (op == stbs_pkg::OP_WRITE) begin
      shadow_keys[idx]    = k;
      shadow_written[idx] = 1'b1;
    end else if (typed) begin
      pending_answers.push_back('{exp_found, exp_index});
    end else begin
      look_up(k, hit, at, hole);
      pending_answers.push_back('{hit, at});
    end
  endtask

  // Hold the input idle until every answer is back, then let the block settle.
  task automatic drain(input int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // entry_count is only changed while the block is idle
  task automatic write_count(input logic [stbs_pkg::CNT_W-1:0] value);
    drain(SETTLE);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    shadow_count = value;
  endtask

  // Result side: random stall before each word, then ready until it is taken.
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
    end
  end

  // Each result word against the oldest queued answer.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("result word with no search pending: found %0d, match_index %0d",
               found, match_index);
        mismatches++;
      end else begin
        head_answer = pending_answers.pop_front();
        if (found !== head_answer.found) begin
          $error("found: expected %0d, got %0d", head_answer.found, found);
          mismatches++;
        end
        if (match_index !== head_answer.match_index) begin
          $error("match_index: expected %0d, got %0d",
                 head_answer.match_index, match_index);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int                                n;
    int                                r;
    int                                j;
    int                                hole;
    logic                              op;
    logic [stbs_pkg::IDX_W-1:0]        idx;
    logic signed [stbs_pkg::KEY_W-1:0] k;
    logic                              hit;
    logic [stbs_pkg::IDX_W-1:0]        at;
    logic [stbs_pkg::CNT_W-1:0]        phase_count;

    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    operation   = stbs_pkg::OP_WRITE;
    entry_index = '0;
    key         = '0;
    calm        = 1'b0;
    shadow_count = '0;
    layout_base = '0;
    layout_step = 32'd1;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_keys[i]    = '0;
      shadow_written[i] = 1'b0;
    end

    // Directed part. Only entries already written are ever probed.
    dir_rows = '{
      // empty table: nothing to probe
      '{ROW_WORD, stbs_pkg::OP_SEARCH, 10'd0,    32'sd0,   11'd0, 1'b1, 1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::OP_WRITE,  10'd0,    KEY_MIN,  11'd0, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::OP_WRITE,  10'd1,    -32'sd5,  11'd0, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::OP_WRITE,  10'd2,    32'sd0,   11'd0, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::OP_WRITE,  10'd3,    32'sd7,   11'd0, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::OP_WRITE,  10'd4,    KEY_MAX,  11'd0, 1'b0, 1'b0, 10'd0},
      '{ROW_CFG,  stbs_pkg::OP_WRITE,  10'd0,    32'sd0,   11'd5, 1'b0, 1'b0, 10'd0},
      // key extremes at the table ends
      '{ROW_WORD, stbs_pkg::OP_SEARCH, 10'd0,    KEY_MIN,  11'd0, 1'b1, 1'b1, 10'd0},
      '{ROW_WORD, stbs_pkg::OP_SEARCH, 10'd1023, KEY_MAX,  11'd0, 1'b1, 1'b1, 10'd4},
      '{ROW_WORD, stbs_pkg::OP_SEARCH, 10'd0,    32'sd7,   11'd0, 1'b1, 1'b1, 10'd3},
      '{ROW_WORD, stbs_pkg::OP_SEARCH, 10'd0,    32'sd1,   11'd0, 1'b1, 1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::OP_SEARCH, 10'd0,    -32'sd6,  11'd0, 1'b0, 1'b0, 10'd0},
      // single entry
      '{ROW_CFG,  stbs_pkg::OP_WRITE,  10'd0,    32'sd0,   11'd1, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::OP_SEARCH, 10'd0,    KEY_MIN,  11'd0, 1'b1, 1'b1, 10'd0},
      '{ROW_WORD, stbs_pkg::OP_SEARCH, 10'd0,    32'sd0,   11'd0, 1'b1, 1'b0, 10'd0},
      // duplicate keys: the first equal entry in probe order wins
      '{ROW_WORD, stbs_pkg::OP_WRITE,  10'd2,    -32'sd5,  11'd0, 1'b0, 1'b0, 10'd0},
      '{ROW_CFG,  stbs_pkg::OP_WRITE,  10'd0,    32'sd0,   11'd5, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::OP_SEARCH, 10'd0,    -32'sd5,  11'd0, 1'b0, 1'b0, 10'd0},
      // unsorted table: the probe order decides
      '{ROW_WORD, stbs_pkg::OP_WRITE,  10'd2,    32'sd100, 11'd0, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::OP_SEARCH, 10'd0,    32'sd100, 11'd0, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::OP_SEARCH, 10'd0,    32'sd7,   11'd0, 1'b0, 1'b0, 10'd0},
      // last table position
      '{ROW_WORD, stbs_pkg::OP_WRITE,  10'd1023, 32'sh5A5A_A5A5,
        11'd0, 1'b0, 1'b0, 10'd0},
      '{ROW_CFG,  stbs_pkg::OP_WRITE,  10'd0,    32'sd0,   11'd0, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::OP_SEARCH, 10'd0,    32'sd5,   11'd0, 1'b1, 1'b0, 10'd0}
    };

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_count(dir_rows[i].cnt);
      end else begin
        send_word(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].key,
                  dir_rows[i].typed, dir_rows[i].found, dir_rows[i].match);
      end
    end

    // Random part: phases of one count each, including the full table and a
    // count past the table end (saturates). Searches mostly look for keys
    // that sit in the table.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 8:    phase_count = 11'd1024;
        1:       phase_count = 11'd3;
        2:       phase_count = 11'd2047;
        3:       phase_count = 11'd0;
        4:       phase_count = 11'd1;
        5:       phase_count = 11'd2;
        6:       phase_count = stbs_pkg::CNT_W'($urandom_range(4, 40));
        default: phase_count = stbs_pkg::CNT_W'($urandom_range(41, 1023));
      endcase
      write_count(phase_count);
      calm        = (p % 4 == 2);
      layout_base = $urandom;
      layout_step = $urandom_range(1, 1 << 16);
      n = (phase_count > DEPTH) ? DEPTH : int'(phase_count);

      for (int w = 0; w < PHASE_WORDS; w++) begin
        r = $urandom_range(0, 99);
        j = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, DEPTH - 1);
        if (r < 25) begin
          op  = stbs_pkg::OP_WRITE;
          idx = stbs_pkg::IDX_W'(j);
          k   = layout_key(j);
        end else if (r < 30) begin
          // noise: any position, any key
          op  = stbs_pkg::OP_WRITE;
          idx = stbs_pkg::IDX_W'($urandom_range(0, DEPTH - 1));
          k   = $urandom;
        end else if (r < 70) begin
          op  = stbs_pkg::OP_SEARCH;
          idx = stbs_pkg::IDX_W'($urandom);
          k   = shadow_written[j] ? shadow_keys[j] : layout_key(j);
        end else if (r < 85) begin
          // near miss, just beside an entry
          op  = stbs_pkg::OP_SEARCH;
          idx = stbs_pkg::IDX_W'($urandom);
          k   = layout_key(j) + (($urandom_range(0, 1) == 1) ? 32'sd1 : -32'sd1);
        end else begin
          op  = stbs_pkg::OP_SEARCH;
          idx = stbs_pkg::IDX_W'($urandom);
          k   = $urandom;
        end

        // a search that would probe a never-written entry fills it instead
        if (op == stbs_pkg::OP_SEARCH) begin
          look_up(k, hit, at, hole);
          if (hole >= 0) begin
            op  = stbs_pkg::OP_WRITE;
            idx = stbs_pkg::IDX_W'(hole);
            k   = layout_key(hole);
          end
        end

        // now and then the sender waits for every answer
        if ($urandom_range(0, 99) < 2) begin
          drain(0);
        end
        send_word(op, idx, k, 1'b0, 1'b0, '0);
      end
    end

    calm = 1'b0;
    drain(SETTLE);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
